@@ hw/rtl/slfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared sizes, types, codes and the sequencer program for the sorted list
// engine.
// ----------------------------------------------------------------------------
package slfp_pkg;

   localparam int POOL_SLOTS = 8;
   localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int LINK_W     = SLOT_W + 1;
   localparam int STEP_W     = $clog2(POOL_SLOTS + 1);
   localparam int KEY_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 3;
   localparam int PC_W       = 4;

   typedef logic [SLOT_W-1:0]       slot_type;
   typedef logic [LINK_W-1:0]       link_type;
   typedef logic [STEP_W-1:0]       step_type;
   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [PC_W-1:0]         pc_type;

   localparam link_type LINK_NIL = '1;

   localparam status_type ST_DONE    = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_MISSING = 2'd2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // program addresses
   localparam pc_type PC_IDLE      = 4'd0;
   localparam pc_type PC_CHECK     = 4'd1;
   localparam pc_type PC_TEST      = 4'd2;
   localparam pc_type PC_DISPATCH  = 4'd3;
   localparam pc_type PC_ALLOC     = 4'd4;
   localparam pc_type PC_FILL      = 4'd5;
   localparam pc_type PC_LINK_NEW  = 4'd6;
   localparam pc_type PC_DEL_CHECK = 4'd7;
   localparam pc_type PC_UNLINK    = 4'd8;
   localparam pc_type PC_RELEASE   = 4'd9;
   localparam pc_type PC_FULL      = 4'd10;
   localparam pc_type PC_MISS      = 4'd11;
   localparam pc_type PC_REPLY     = 4'd12;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_NO_CUR,
      COND_ADVANCE,
      COND_DELETE,
      COND_NO_FREE,
      COND_MISSING,
      COND_OUT_FREE
   } cond_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_WALK,
      ACT_FILL,
      ACT_LINK_NEW,
      ACT_LINK_NEXT,
      ACT_RELEASE,
      ACT_FULL,
      ACT_MISS,
      ACT_REPLY
   } act_type;

   // rd_en/rd_free: read the pool at cur or at the free head.
   // cond true: jump to target; false: stay or fall through.
   typedef struct packed {
      logic     rd_en;
      logic     rd_free;
      cond_type cond;
      logic     stay;
      pc_type   target;
      act_type  act;
   } ucode_type;

   function automatic logic is_slot(link_type l);
      return l < LINK_W'(POOL_SLOTS);
   endfunction

   function automatic link_type reset_link(slot_type s);
      link_type r;
      if (int'(s) + 1 < POOL_SLOTS) r = LINK_W'(int'(s) + 1);
      else                          r = LINK_NIL;
      return r;
   endfunction

   function automatic ucode_type uword(logic rd_en, logic rd_free, cond_type c,
                                      logic stay, pc_type t, act_type a);
      ucode_type w;
      w.rd_en   = rd_en;
      w.rd_free = rd_free;
      w.cond    = c;
      w.stay    = stay;
      w.target  = t;
      w.act     = a;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(pc_type pc);
      ucode_type w;
      case (pc)
         PC_IDLE:      w = uword(1'b0, 1'b0, COND_REQ,      1'b1, PC_CHECK,     ACT_LOAD);
         PC_CHECK:     w = uword(1'b1, 1'b0, COND_NO_CUR,   1'b0, PC_DISPATCH,  ACT_NONE);
         PC_TEST:      w = uword(1'b0, 1'b0, COND_ADVANCE,  1'b0, PC_CHECK,     ACT_WALK);
         PC_DISPATCH:  w = uword(1'b0, 1'b0, COND_DELETE,   1'b0, PC_DEL_CHECK, ACT_NONE);
         PC_ALLOC:     w = uword(1'b1, 1'b1, COND_NO_FREE,  1'b0, PC_FULL,      ACT_NONE);
         PC_FILL:      w = uword(1'b0, 1'b0, COND_ALWAYS,   1'b0, PC_LINK_NEW,  ACT_FILL);
         PC_LINK_NEW:  w = uword(1'b0, 1'b0, COND_ALWAYS,   1'b0, PC_REPLY,     ACT_LINK_NEW);
         PC_DEL_CHECK: w = uword(1'b0, 1'b0, COND_MISSING,  1'b0, PC_MISS,      ACT_NONE);
         PC_UNLINK:    w = uword(1'b0, 1'b0, COND_ALWAYS,   1'b0, PC_RELEASE,   ACT_LINK_NEXT);
         PC_RELEASE:   w = uword(1'b0, 1'b0, COND_ALWAYS,   1'b0, PC_REPLY,     ACT_RELEASE);
         PC_FULL:      w = uword(1'b0, 1'b0, COND_ALWAYS,   1'b0, PC_REPLY,     ACT_FULL);
         PC_MISS:      w = uword(1'b0, 1'b0, COND_ALWAYS,   1'b0, PC_REPLY,     ACT_MISS);
         PC_REPLY:     w = uword(1'b0, 1'b0, COND_OUT_FREE, 1'b1, PC_IDLE,      ACT_REPLY);
         default:      w = uword(1'b0, 1'b0, COND_ALWAYS,   1'b0, PC_IDLE,      ACT_NONE);
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/sorted_list_in_fixed_pool_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_in_fixed_pool_core
// Ascending linked list of signed byte keys in a fixed slot pool, driven by a
// small microprogram.
// ----------------------------------------------------------------------------
// Each request transaction is one insert or delete and yields one response
// transaction. The pool has a single read port, so the walk reads each list
// entry in PC_CHECK and compares it in PC_TEST. The time from acceptance to
// the next acceptance grows with the number of entries passed before the
// insert point or the match, and with any stall on the response side. The
// request side is stalled from acceptance until the response is registered;
// a finished response may wait on the output while the next request is taken.
// Inserts into a full pool report status 1, deletes of an absent key status 2,
// both with slot 0. Equal keys are inserted ahead of existing equal keys.
module sorted_list_in_fixed_pool_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  slfp_pkg::key_type                 req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output slfp_pkg::status_type              rsp_status,
   output logic [slfp_pkg::SLOT_OUT_W-1:0]   rsp_slot
);
   import slfp_pkg::*;

   ucode_type  uc;
   logic       taken;
   logic       walk_more;
   pc_type     pc_ff, pc_in;

   logic       mode_ff, mode_in;
   key_type    key_ff, key_in;
   link_type   cur_ff, cur_in;
   link_type   prev_ff, prev_in;
   link_type   free_ff, free_in;
   link_type   head_ff, head_in;
   step_type   steps_ff, steps_in;
   logic       found_ff, found_in;
   status_type status_ff, status_in;
   slot_type   slot_ff, slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // pool storage
   key_type         key_mem [POOL_SLOTS];
   link_type        link_mem [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] link_valid_ff;
   key_type         key_rd_ff;
   link_type        link_rd_ff;
   slot_type        rd_addr;

   logic            lw_en;
   slot_type        lw_addr;
   link_type        lw_data;
   logic            kw_en;

   assign uc        = ucode_rom(pc_ff);
   assign req_stall = (uc.act != ACT_LOAD);
   assign rd_addr   = uc.rd_free ? free_ff[SLOT_W-1:0] : cur_ff[SLOT_W-1:0];

   assign walk_more = (steps_ff < STEP_W'(POOL_SLOTS)) &&
                      ((mode_ff == MODE_DELETE) ? (key_rd_ff != key_ff)
                                                : (key_rd_ff < key_ff));

   always_comb begin
      case (uc.cond)
         COND_ALWAYS:   taken = 1'b1;
         COND_REQ:      taken = req_valid;
         COND_NO_CUR:   taken = !is_slot(cur_ff);
         COND_ADVANCE:  taken = walk_more;
         COND_DELETE:   taken = (mode_ff == MODE_DELETE);
         COND_NO_FREE:  taken = !is_slot(free_ff);
         COND_MISSING:  taken = !found_ff;
         COND_OUT_FREE: taken = !rsp_valid_ff || !rsp_stall;
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      if (taken)        pc_in = uc.target;
      else if (uc.stay) pc_in = pc_ff;
      else              pc_in = pc_ff + 1'b1;
   end

   always_comb begin
      mode_in       = mode_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      free_in       = free_ff;
      head_in       = head_ff;
      steps_in      = steps_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      lw_en         = 1'b0;
      lw_addr       = cur_ff[SLOT_W-1:0];
      lw_data       = free_ff;
      kw_en         = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (uc.act)
         ACT_LOAD: begin
            if (taken) begin
               mode_in   = req_mode;
               key_in    = req_key;
               cur_in    = head_ff;
               prev_in   = LINK_NIL;
               steps_in  = '0;
               found_in  = 1'b0;
               status_in = ST_DONE;
               slot_in   = '0;
            end
         end
         ACT_WALK: begin
            found_in = (mode_ff == MODE_DELETE) && (key_rd_ff == key_ff);
            if (taken) begin
               prev_in  = cur_ff;
               cur_in   = link_rd_ff;
               steps_in = steps_ff + 1'b1;
            end
         end
         ACT_FILL: begin
            kw_en   = 1'b1;
            lw_en   = 1'b1;
            lw_addr = free_ff[SLOT_W-1:0];
            lw_data = cur_ff;
            free_in = link_rd_ff;
            slot_in = free_ff[SLOT_W-1:0];
         end
         ACT_LINK_NEW: begin
            if (is_slot(prev_ff)) begin
               lw_en   = 1'b1;
               lw_addr = prev_ff[SLOT_W-1:0];
               lw_data = LINK_W'(slot_ff);
            end else begin
               head_in = LINK_W'(slot_ff);
            end
         end
         ACT_LINK_NEXT: begin
            if (is_slot(prev_ff)) begin
               lw_en   = 1'b1;
               lw_addr = prev_ff[SLOT_W-1:0];
               lw_data = link_rd_ff;
            end else begin
               head_in = link_rd_ff;
            end
         end
         ACT_RELEASE: begin
            lw_en   = 1'b1;
            lw_addr = cur_ff[SLOT_W-1:0];
            lw_data = free_ff;
            free_in = cur_ff;
            slot_in = cur_ff[SLOT_W-1:0];
         end
         ACT_FULL:    status_in = ST_FULL;
         ACT_MISS:    status_in = ST_MISSING;
         ACT_REPLY: begin
            if (taken) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = SLOT_OUT_W'(slot_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= PC_IDLE;
         free_ff       <= '0;
         head_ff       <= LINK_NIL;
         rsp_valid_ff  <= 1'b0;
         link_valid_ff <= '0;
      end else begin
         pc_ff        <= pc_in;
         free_ff      <= free_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (lw_en) link_valid_ff[lw_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // pool: one write per array, registered read at one address
   always_ff @(posedge clock) begin
      if (kw_en) key_mem[free_ff[SLOT_W-1:0]] <= key_ff;
      if (lw_en) link_mem[lw_addr] <= lw_data;
      if (uc.rd_en) begin
         key_rd_ff  <= key_mem[rd_addr];
         link_rd_ff <= link_valid_ff[rd_addr] ? link_mem[rd_addr] : reset_link(rd_addr);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

@@ hw/rtl/slfp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfp_checker
// Port-level checks for the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
module slfp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input slfp_pkg::status_type            rsp_status,
   input logic [slfp_pkg::SLOT_OUT_W-1:0] rsp_slot
);
   import slfp_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE) || (rsp_status == ST_FULL) ||
                    (rsp_status == ST_MISSING))
      else $error("response carries an unknown status");

   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> (rsp_slot == '0))
      else $error("failed transaction reports a slot");

   // one transaction at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind sorted_list_in_fixed_pool_core slfp_checker u_slfp_checker (.*);

@@ verif/sorted_list_in_fixed_pool_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_in_fixed_pool_core_tb
// Checks the sorted list engine against a cycle-free software copy of the
// slot pool. A driver pops queued insert/delete operations onto the request
// channel, and the expected status and slot of every accepted operation are
// worked out at acceptance. A monitor compares each response in order. The
// run covers full pool, absent keys, equal keys and extreme keys. It steps
// through several sender/receiver idling mixes and one long response hold
// that backs up the request side.
// ----------------------------------------------------------------------------
module sorted_list_in_fixed_pool_core_tb;
   import slfp_pkg::*;

   localparam int HOLD_CYCLES  = 250;
   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 60;

   typedef struct {
      logic    mode;
      key_type key;
   } list_op_type;

   typedef struct {
      status_type                status;
      logic [SLOT_OUT_W-1:0]     slot;
   } list_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = MODE_INSERT;
   key_type                 req_key = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b1;
   status_type              rsp_status;
   logic [SLOT_OUT_W-1:0]   rsp_slot;

   // software copy of the pool
   key_type  pool_key  [POOL_SLOTS];
   link_type pool_link [POOL_SLOTS];
   link_type free_top;
   link_type list_top;

   list_op_type     pending_ops[$];
   list_result_type awaited_results[$];
   list_op_type     next_op;
   list_result_type want;
   list_result_type got;

   int error_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic hold_req = 1'b0;
   int hold_left = 0;

   sorted_list_in_fixed_pool_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic in_pool(link_type l);
      return int'(l) < POOL_SLOTS;
   endfunction

   // Apply one operation to the software pool and return its response.
   function automatic list_result_type list_apply(logic mode, key_type key);
      list_result_type r;
      link_type prev;
      link_type cur;
      link_type taken;
      int steps;
      prev     = LINK_NIL;
      cur      = list_top;
      steps    = 0;
      r.status = ST_DONE;
      r.slot   = '0;
      if (mode == MODE_INSERT) begin
         while (in_pool(cur) && steps < POOL_SLOTS && pool_key[cur[SLOT_W-1:0]] < key) begin
            prev = cur;
            cur  = pool_link[cur[SLOT_W-1:0]];
            steps++;
         end
         if (!in_pool(cur)) cur = LINK_NIL;
         if (!in_pool(free_top)) begin
            r.status = ST_FULL;
         end else begin
            taken = free_top;
            free_top = pool_link[taken[SLOT_W-1:0]];
            pool_key[taken[SLOT_W-1:0]]  = key;
            pool_link[taken[SLOT_W-1:0]] = cur;
            if (in_pool(prev)) pool_link[prev[SLOT_W-1:0]] = taken;
            else               list_top = taken;
            r.slot = SLOT_OUT_W'(taken);
         end
      end else begin
         while (in_pool(cur) && steps < POOL_SLOTS && pool_key[cur[SLOT_W-1:0]] != key) begin
            prev = cur;
            cur  = pool_link[cur[SLOT_W-1:0]];
            steps++;
         end
         if (in_pool(cur) && pool_key[cur[SLOT_W-1:0]] == key) begin
            if (in_pool(prev)) pool_link[prev[SLOT_W-1:0]] = pool_link[cur[SLOT_W-1:0]];
            else               list_top = pool_link[cur[SLOT_W-1:0]];
            pool_link[cur[SLOT_W-1:0]] = free_top;
            free_top = cur;
            r.slot = SLOT_OUT_W'(cur);
         end else begin
            r.status = ST_MISSING;
         end
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_mode  <= MODE_INSERT;
         req_key   <= '0;
      end else begin
         if (req_valid && !req_stall)
            awaited_results.push_back(list_apply(req_mode, req_key));
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_mode  <= next_op.mode;
               req_key   <= next_op.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.slot   = rsp_slot;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected response status=%0d slot=%0d",
                        $time, got.status, got.slot);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch expected=%0d actual=%0d",
                           $time, want.status, got.status);
                  error_count++;
               end
               if (got.slot !== want.slot) begin
                  $display("%0t: slot mismatch expected=%0d actual=%0d",
                           $time, want.slot, got.slot);
                  error_count++;
               end
            end
         end
         if (hold_req)            hold_left <= HOLD_CYCLES;
         else if (hold_left != 0) hold_left <= hold_left - 1;
         rsp_stall <= hold_req || hold_left > 1
                      || ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // end the run if no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else                                                        quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic queue_op(input logic mode, input key_type key);
      list_op_type op;
      op.mode = mode;
      op.key  = key;
      pending_ops.push_back(op);
   endtask

   // Alternate insert-heavy and delete-heavy runs so the pool swings between
   // full and empty; half of the keys come from a narrow band to get hits and ties.
   task automatic queue_random(input int count);
      int n;
      int fill_pct;
      int pick;
      key_type k;
      fill_pct = 30;
      for (n = 0; n < count; n++) begin
         if (n % 24 == 0) fill_pct = (fill_pct == 75) ? 30 : 75;
         pick = $urandom_range(0, 99);
         if (pick < 50)      k = key_type'(int'($urandom_range(0, 7)) - 4);
         else if (pick < 65) k = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
         else                k = key_type'($urandom);
         queue_op(($urandom_range(0, 99) < fill_pct) ? MODE_INSERT : MODE_DELETE, k);
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int i;
      for (i = 0; i < POOL_SLOTS; i++) begin
         pool_key[SLOT_W'(i)]  = '0;
         pool_link[SLOT_W'(i)] = (i + 1 < POOL_SLOTS) ? LINK_W'(i + 1) : LINK_NIL;
      end
      free_top = '0;
      list_top = LINK_NIL;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty delete, extremes, ties, full pool, absent key, drain
      queue_op(MODE_DELETE, 8'sd0);
      queue_op(MODE_INSERT, 8'sh7f);
      queue_op(MODE_INSERT, 8'sh80);
      queue_op(MODE_INSERT, 8'sd0);
      queue_op(MODE_INSERT, -8'sd1);
      queue_op(MODE_INSERT, 8'sd0);
      queue_op(MODE_INSERT, 8'sd1);
      queue_op(MODE_INSERT, 8'sh80);
      queue_op(MODE_INSERT, 8'sh7f);
      queue_op(MODE_INSERT, 8'sd64);
      queue_op(MODE_DELETE, 8'sd0);
      queue_op(MODE_DELETE, 8'sd42);
      queue_op(MODE_DELETE, 8'sh7f);
      queue_op(MODE_DELETE, 8'sh80);
      queue_op(MODE_DELETE, -8'sd1);
      queue_op(MODE_DELETE, 8'sd0);
      queue_op(MODE_DELETE, 8'sd1);
      queue_op(MODE_DELETE, 8'sh80);
      queue_op(MODE_DELETE, 8'sh7f);
      queue_op(MODE_DELETE, 8'sh80);
      queue_op(MODE_INSERT, 8'sh55);
      queue_op(MODE_INSERT, 8'shaa);
      wait_drained();

      queue_random(150);
      wait_drained();

      sender_idle_pct = 86;
      queue_random(150);
      wait_drained();

      sender_idle_pct = 0;
      receiver_stall_pct = 86;
      queue_random(150);
      wait_drained();

      // hold the response side so the request side backs up
      receiver_stall_pct = 0;
      queue_random(40);
      repeat (3) @(negedge clock);
      hold_req = 1'b1;
      @(negedge clock);
      hold_req = 1'b0;
      wait_drained();

      // pause the sender midway until every response is back
      sender_idle_pct = 16;
      receiver_stall_pct = 16;
      queue_random(100);
      wait_drained();
      queue_random(100);
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && awaited_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/slfp_pkg.sv
hw/rtl/sorted_list_in_fixed_pool_core.sv
hw/rtl/slfp_checker.sv
verif/sorted_list_in_fixed_pool_core_tb.sv
